>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an expression is never true
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

>>> rtl/asmf_pkg.sv
`default_nettype none
package asmf_pkg;

	typedef enum logic [2:0] {
		MODE_OFF      = 3'd0,
		MODE_MANUAL   = 3'd1,
		MODE_READY    = 3'd2,
		MODE_DRIVING  = 3'd3,
		MODE_EMERG    = 3'd4,
		MODE_FINISHED = 3'd5
	} mode_t;

	localparam logic [1:0] TASK_MANUAL = 2'd1;
	localparam logic [1:0] TASK_AUTO   = 2'd2;

	localparam logic [1:0] BRAKE_OFF    = 2'd0;
	localparam logic [1:0] BRAKE_HELD   = 2'd1;
	localparam logic [1:0] BRAKE_ACTIVE = 2'd2;

	localparam logic [2:0] LIGHT_OFF          = 3'd0;
	localparam logic [2:0] LIGHT_YELLOW       = 3'd1;
	localparam logic [2:0] LIGHT_YELLOW_BLINK = 3'd2;
	localparam logic [2:0] LIGHT_BLUE         = 3'd3;
	localparam logic [2:0] LIGHT_BLUE_BLINK   = 3'd4;

	localparam logic [1:0] BUZ_SILENT = 2'd0;
	localparam logic [1:0] BUZ_ALARM  = 2'd1;
	localparam logic [1:0] BUZ_R2D    = 2'd2;

	typedef struct packed {
		logic       ts_closed;
		logic       asms_closed;
		logic       ebs_enabled;
		logic       brake_motor_ok;
		logic [1:0] acu_mode;
		logic       res_event;
		logic       go_event;
		logic       task_done;
		logic       brake_released;
		logic       beep_done;
		logic       r2d_done;
	} item_t;

	typedef struct packed {
		mode_t      mode;
		logic       cause_is_fault;
		logic       alarm_beep;
		logic       r2d_active;
		logic       go_wait_flag;
		logic       res_pending;
		logic       go_pending;
		logic [1:0] buzzer;
	} state_t;

	typedef struct packed {
		logic [2:0] mode_now;
		logic       steer_enable;
		logic [1:0] brake_cmd;
		logic [2:0] light_mode;
		logic       ebs_fire;
		logic       redundant_brake;
		logic       fault_led;
		logic [1:0] buzzer_mode;
		logic       go_wait_run;
		logic       r2d_run;
		logic       mode_pin;
		logic       close_sdc_pin;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/asmf_core.sv
`default_nettype none
module asmf_core
	import asmf_pkg::*;
(
	input  state_t cur,
	input  item_t  item,
	output state_t nxt,
	output res_t   res
);

	logic res_p;
	logic go_p;
	logic fault;
	state_t tr;

	assign res_p = cur.res_pending | item.res_event;
	assign go_p  = cur.go_pending | item.go_event;
	assign fault = !item.ebs_enabled || res_p || !item.ts_closed || !item.asms_closed;

	always_comb begin
		tr = cur;
		tr.res_pending = res_p;
		tr.go_pending  = go_p;
		case (cur.mode)
			MODE_OFF: begin
				if (item.asms_closed && item.ts_closed && item.ebs_enabled &&
						item.brake_motor_ok && item.acu_mode == TASK_AUTO) begin
					tr.go_pending   = 1'b0;
					tr.go_wait_flag = 1'b1;
					tr.mode         = MODE_READY;
				end else if (!item.asms_closed && !item.ebs_enabled && item.ts_closed &&
						item.acu_mode == TASK_MANUAL) begin
					tr.mode = MODE_MANUAL;
				end
			end
			MODE_MANUAL: begin
				if (!item.ts_closed)
					tr.mode = MODE_OFF;
			end
			MODE_READY, MODE_DRIVING: begin
				if (fault) begin
					tr.mode           = MODE_EMERG;
					tr.cause_is_fault = !item.ebs_enabled;
					tr.alarm_beep     = 1'b1;
					tr.buzzer         = BUZ_R2D;
					if (item.ebs_enabled)
						tr.res_pending = 1'b0;
					if (cur.mode == MODE_READY)
						tr.go_wait_flag = 1'b0;
					else
						tr.r2d_active = 1'b0;
				end else if (cur.mode == MODE_READY) begin
					if (go_p) begin
						tr.go_pending = 1'b0;
						tr.r2d_active = 1'b1;
						tr.mode       = MODE_DRIVING;
					end
				end else if (item.task_done) begin
					tr.r2d_active = 1'b0;
					tr.buzzer     = BUZ_SILENT;
					tr.mode       = MODE_FINISHED;
				end
			end
			MODE_EMERG: begin
				if (!cur.alarm_beep && !item.asms_closed && item.brake_released)
					tr.mode = MODE_OFF;
			end
			MODE_FINISHED: begin
				if (res_p) begin
					tr.res_pending = 1'b0;
					tr.mode        = MODE_EMERG;
					tr.alarm_beep  = 1'b1;
					tr.buzzer      = BUZ_R2D;
				end else if (!item.asms_closed && item.brake_released) begin
					tr.mode = MODE_OFF;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nxt = tr;
		// keep a flag whose timer restarted this tick
		if (item.beep_done && !(tr.alarm_beep && !cur.alarm_beep))
			nxt.alarm_beep = 1'b0;
		if (item.r2d_done && !(tr.r2d_active && !cur.r2d_active))
			nxt.r2d_active = 1'b0;

		res.steer_enable    = 1'b0;
		res.brake_cmd       = BRAKE_OFF;
		res.light_mode      = LIGHT_OFF;
		res.ebs_fire        = 1'b0;
		res.redundant_brake = 1'b0;
		res.fault_led       = 1'b0;
		case (tr.mode)
			MODE_READY: begin
				res.steer_enable = 1'b1;
				res.brake_cmd    = BRAKE_HELD;
				res.light_mode   = LIGHT_YELLOW;
			end
			MODE_DRIVING: begin
				nxt.buzzer       = nxt.r2d_active ? BUZ_R2D : BUZ_SILENT;
				res.steer_enable = 1'b1;
				res.brake_cmd    = BRAKE_ACTIVE;
				res.light_mode   = LIGHT_YELLOW_BLINK;
			end
			MODE_FINISHED: begin
				res.ebs_fire   = 1'b1;
				res.brake_cmd  = BRAKE_ACTIVE;
				res.light_mode = LIGHT_BLUE;
			end
			MODE_EMERG: begin
				nxt.buzzer          = nxt.alarm_beep ? BUZ_ALARM : BUZ_SILENT;
				res.ebs_fire        = 1'b1;
				res.light_mode      = LIGHT_BLUE_BLINK;
				res.redundant_brake = tr.cause_is_fault;
				res.fault_led       = tr.cause_is_fault;
			end
			default: begin
			end
		endcase

		res.mode_now      = tr.mode;
		res.buzzer_mode   = nxt.buzzer;
		res.go_wait_run   = nxt.go_wait_flag;
		res.r2d_run       = nxt.r2d_active;
		res.mode_pin      = (item.acu_mode != TASK_MANUAL);
		res.close_sdc_pin = (item.acu_mode == TASK_AUTO);
	end

endmodule
`default_nettype wire

>>> rtl/autonomous_system_mode_fsm.sv
// An item is held in item_s1, then its result is registered in res_q.
// Throughput: one item per cycle while result_stall is low; the mode and flag
// registers close their loop through the single combinational transition stage.
// Reset (arst_n low, asynchronous): mode off, all flags and buzzer cleared,
// both pipeline valid bits cleared.
`default_nettype none
`include "assert_macros.svh"
module autonomous_system_mode_fsm
	import asmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       ts_closed,
	input  logic       asms_closed,
	input  logic       ebs_enabled,
	input  logic       brake_motor_ok,
	input  logic [1:0] acu_mode,
	input  logic       res_event,
	input  logic       go_event,
	input  logic       task_done,
	input  logic       brake_released,
	input  logic       beep_done,
	input  logic       r2d_done,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] mode_now,
	output logic       steer_enable,
	output logic [1:0] brake_cmd,
	output logic [2:0] light_mode,
	output logic       ebs_fire,
	output logic       redundant_brake,
	output logic       fault_led,
	output logic [1:0] buzzer_mode,
	output logic       go_wait_run,
	output logic       r2d_run,
	output logic       mode_pin,
	output logic       close_sdc_pin
);

	logic   valid_s1;
	item_t  item_s1;
	logic   out_valid_q;
	res_t   res_q;
	state_t state_q;
	state_t state_nxt;
	res_t   res_nxt;
	logic   out_free;
	logic   adv;
	logic   take;

	assign out_free   = !out_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	asmf_core u_core (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{ts_closed, asms_closed, ebs_enabled, brake_motor_ok, acu_mode,
				res_event, go_event, task_done, brake_released, beep_done, r2d_done};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, BUZ_SILENT};
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				state_q <= state_nxt;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign result_valid    = out_valid_q;
	assign mode_now        = res_q.mode_now;
	assign steer_enable    = res_q.steer_enable;
	assign brake_cmd       = res_q.brake_cmd;
	assign light_mode      = res_q.light_mode;
	assign ebs_fire        = res_q.ebs_fire;
	assign redundant_brake = res_q.redundant_brake;
	assign fault_led       = res_q.fault_led;
	assign buzzer_mode     = res_q.buzzer_mode;
	assign go_wait_run     = res_q.go_wait_run;
	assign r2d_run         = res_q.r2d_run;
	assign mode_pin        = res_q.mode_pin;
	assign close_sdc_pin   = res_q.close_sdc_pin;

	`ASSERT_NEVER(a_stall_empty, item_stall && !valid_s1, "stall without a held item")
	`ASSERT_CLK(a_state_hold, !adv |=> $stable(state_q), "state moved without a transfer")
	`ASSERT_CLK(a_go_consumed, adv && state_q.mode == MODE_OFF && state_nxt.mode == MODE_READY
		|=> !state_q.go_pending, "go pending left set on entering ready")
	`ASSERT_CLK(a_result_source, $rose(out_valid_q) |-> $past(valid_s1),
		"result without a held item")

endmodule
`default_nettype wire

>>> tb/asmf_mode_checker.sv
module asmf_mode_checker
	import asmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       ts_closed,
	input  logic       asms_closed,
	input  logic       ebs_enabled,
	input  logic       brake_motor_ok,
	input  logic [1:0] acu_mode,
	input  logic       res_event,
	input  logic       go_event,
	input  logic       task_done,
	input  logic       brake_released,
	input  logic       beep_done,
	input  logic       r2d_done,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic [2:0] mode_now,
	input  logic       steer_enable,
	input  logic [1:0] brake_cmd,
	input  logic [2:0] light_mode,
	input  logic       ebs_fire,
	input  logic       redundant_brake,
	input  logic       fault_led,
	input  logic [1:0] buzzer_mode,
	input  logic       go_wait_run,
	input  logic       r2d_run,
	input  logic       mode_pin,
	input  logic       close_sdc_pin,
	output int         fail_count,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	state_t sup_st = '0;
	res_t   expected_cmds[$];
	item_t  seen_item;
	res_t   got_cmd;
	res_t   want_cmd;
	int     n_results = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [2:0] got,
			input logic [2:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				n_results, name, got, want));
	endtask

	// Shared exit of ready and driving; returns 1 when emergency is entered.
	function automatic logic take_fault_exit(input item_t it);
		logic fault;
		logic hit;
		fault = !it.ebs_enabled;
		hit = fault || sup_st.res_pending || !it.ts_closed || !it.asms_closed;
		if (!fault && sup_st.res_pending)
			sup_st.res_pending = 1'b0;
		if (hit) begin
			sup_st.mode = MODE_EMERG;
			sup_st.cause_is_fault = fault;
			sup_st.alarm_beep = 1'b1;
			sup_st.buzzer = BUZ_R2D;
		end
		return hit;
	endfunction

	function automatic res_t next_commands(input item_t it);
		res_t r;
		logic alarm_was;
		logic r2d_was;
		alarm_was = sup_st.alarm_beep;
		r2d_was = sup_st.r2d_active;
		r = '0;
		if (it.res_event)
			sup_st.res_pending = 1'b1;
		if (it.go_event)
			sup_st.go_pending = 1'b1;

		case (sup_st.mode)
		MODE_OFF: begin
			if (it.asms_closed && it.ts_closed && it.ebs_enabled && it.brake_motor_ok
					&& it.acu_mode == TASK_AUTO) begin
				sup_st.go_pending = 1'b0;
				sup_st.go_wait_flag = 1'b1;
				sup_st.mode = MODE_READY;
			end else if (!it.asms_closed && !it.ebs_enabled && it.ts_closed
					&& it.acu_mode == TASK_MANUAL) begin
				sup_st.mode = MODE_MANUAL;
			end
		end
		MODE_MANUAL: begin
			if (!it.ts_closed)
				sup_st.mode = MODE_OFF;
		end
		MODE_READY: begin
			if (take_fault_exit(it)) begin
				sup_st.go_wait_flag = 1'b0;
			end else if (sup_st.go_pending) begin
				sup_st.go_pending = 1'b0;
				sup_st.r2d_active = 1'b1;
				sup_st.mode = MODE_DRIVING;
			end
		end
		MODE_DRIVING: begin
			if (take_fault_exit(it)) begin
				sup_st.r2d_active = 1'b0;
			end else if (it.task_done) begin
				sup_st.r2d_active = 1'b0;
				sup_st.buzzer = BUZ_SILENT;
				sup_st.mode = MODE_FINISHED;
			end
		end
		MODE_EMERG: begin
			if (!sup_st.alarm_beep && !it.asms_closed && it.brake_released)
				sup_st.mode = MODE_OFF;
		end
		MODE_FINISHED: begin
			if (sup_st.res_pending) begin
				sup_st.res_pending = 1'b0;
				sup_st.mode = MODE_EMERG;
				sup_st.alarm_beep = 1'b1;
				sup_st.buzzer = BUZ_R2D;
			end else if (!it.asms_closed && it.brake_released) begin
				sup_st.mode = MODE_OFF;
			end
		end
		default: ;
		endcase

		// drop a timer end that lands on the tick that restarted its flag
		if (it.beep_done && !(sup_st.alarm_beep && !alarm_was))
			sup_st.alarm_beep = 1'b0;
		if (it.r2d_done && !(sup_st.r2d_active && !r2d_was))
			sup_st.r2d_active = 1'b0;

		case (sup_st.mode)
		MODE_READY: begin
			r.steer_enable = 1'b1;
			r.brake_cmd = BRAKE_HELD;
			r.light_mode = LIGHT_YELLOW;
		end
		MODE_DRIVING: begin
			sup_st.buzzer = sup_st.r2d_active ? BUZ_R2D : BUZ_SILENT;
			r.steer_enable = 1'b1;
			r.brake_cmd = BRAKE_ACTIVE;
			r.light_mode = LIGHT_YELLOW_BLINK;
		end
		MODE_FINISHED: begin
			r.ebs_fire = 1'b1;
			r.brake_cmd = BRAKE_ACTIVE;
			r.light_mode = LIGHT_BLUE;
		end
		MODE_EMERG: begin
			sup_st.buzzer = sup_st.alarm_beep ? BUZ_ALARM : BUZ_SILENT;
			r.ebs_fire = 1'b1;
			r.light_mode = LIGHT_BLUE_BLINK;
			r.redundant_brake = sup_st.cause_is_fault;
			r.fault_led = sup_st.cause_is_fault;
		end
		default: begin
			r.brake_cmd = BRAKE_OFF;
			r.light_mode = LIGHT_OFF;
		end
		endcase

		r.mode_now = sup_st.mode;
		r.buzzer_mode = sup_st.buzzer;
		r.go_wait_run = sup_st.go_wait_flag;
		r.r2d_run = sup_st.r2d_active;
		r.mode_pin = (it.acu_mode != TASK_MANUAL);
		r.close_sdc_pin = (it.acu_mode == TASK_AUTO);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_st = '0;
			expected_cmds.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				seen_item = {ts_closed, asms_closed, ebs_enabled, brake_motor_ok, acu_mode,
					res_event, go_event, task_done, brake_released, beep_done, r2d_done};
				expected_cmds.push_back(next_commands(seen_item));
			end
			if (result_valid && !result_stall) begin
				got_cmd = {mode_now, steer_enable, brake_cmd, light_mode, ebs_fire,
					redundant_brake, fault_led, buzzer_mode, go_wait_run, r2d_run,
					mode_pin, close_sdc_pin};
				if (expected_cmds.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						n_results));
				end else begin
					want_cmd = expected_cmds.pop_front();
					check_field("mode_now", got_cmd.mode_now, want_cmd.mode_now);
					check_field("steer_enable", got_cmd.steer_enable, want_cmd.steer_enable);
					check_field("brake_cmd", got_cmd.brake_cmd, want_cmd.brake_cmd);
					check_field("light_mode", got_cmd.light_mode, want_cmd.light_mode);
					check_field("ebs_fire", got_cmd.ebs_fire, want_cmd.ebs_fire);
					check_field("redundant_brake", got_cmd.redundant_brake,
						want_cmd.redundant_brake);
					check_field("fault_led", got_cmd.fault_led, want_cmd.fault_led);
					check_field("buzzer_mode", got_cmd.buzzer_mode, want_cmd.buzzer_mode);
					check_field("go_wait_run", got_cmd.go_wait_run, want_cmd.go_wait_run);
					check_field("r2d_run", got_cmd.r2d_run, want_cmd.r2d_run);
					check_field("mode_pin", got_cmd.mode_pin, want_cmd.mode_pin);
					check_field("close_sdc_pin", got_cmd.close_sdc_pin,
						want_cmd.close_sdc_pin);
				end
				n_results++;
			end
			outstanding <= expected_cmds.size();
		end
	end

endmodule

>>> tb/autonomous_system_mode_fsm_tb.sv
module autonomous_system_mode_fsm_tb
	import asmf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 12;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM = 1750;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [1:0] TASK_DEFAULT = 2'd0;
	localparam logic [1:0] TASK_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic       ts_closed;
	logic       asms_closed;
	logic       ebs_enabled;
	logic       brake_motor_ok;
	logic [1:0] acu_mode;
	logic       res_event;
	logic       go_event;
	logic       task_done;
	logic       brake_released;
	logic       beep_done;
	logic       r2d_done;
	logic       result_valid;
	logic       result_stall;
	logic [2:0] mode_now;
	logic       steer_enable;
	logic [1:0] brake_cmd;
	logic [2:0] light_mode;
	logic       ebs_fire;
	logic       redundant_brake;
	logic       fault_led;
	logic [1:0] buzzer_mode;
	logic       go_wait_run;
	logic       r2d_run;
	logic       mode_pin;
	logic       close_sdc_pin;
	int         fail_count;
	int         outstanding;
	int         n_sent = 0;
	int         idle_cycles = 0;

	autonomous_system_mode_fsm u_top (.*);

	asmf_mode_checker u_check (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic offer_tick(input item_t it);
		int gap;
		{ts_closed, asms_closed, ebs_enabled, brake_motor_ok, acu_mode, res_event, go_event,
			task_done, brake_released, beep_done, r2d_done} <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		n_sent++;
		gap = ((n_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic item_t cruise_item(input bit go, input bit done, input int res_pct);
		item_t it;
		it = 12'($urandom);
		it.ts_closed = 1'b1;
		it.asms_closed = 1'b1;
		it.ebs_enabled = 1'b1;
		it.brake_motor_ok = ($urandom_range(0, 9) != 0);
		it.acu_mode = ($urandom_range(0, 7) == 0) ? 2'($urandom) : TASK_AUTO;
		it.res_event = ($urandom_range(0, 99) < res_pct);
		it.go_event = go;
		it.task_done = done;
		case ($urandom_range(0, 39))
		0: it.ts_closed = 1'b0;
		1: it.asms_closed = 1'b0;
		2: it.ebs_enabled = 1'b0;
		default: ;
		endcase
		return it;
	endfunction

	// open both switches with brakes released and beep over: any mode settles to off
	function automatic item_t recover_item();
		item_t it;
		it = 12'($urandom);
		it.ts_closed = 1'b0;
		it.asms_closed = 1'b0;
		it.res_event = 1'b0;
		it.brake_released = 1'b1;
		it.beep_done = 1'b1;
		return it;
	endfunction

	initial begin
		int rx_wait;
		int rx_done;
		rx_wait = 0;
		rx_done = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				rx_done++;
				if (rx_done == 300 || rx_done == 1100)
					rx_wait = 250;
				else if (rx_done % 120 >= 90)
					rx_wait = 0;
				else
					rx_wait = $urandom_range(0, 10);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		item_t it;
		int k;
		bit paused;
		arst_n = 1'b0;
		item_valid = 1'b0;
		{ts_closed, asms_closed, ebs_enabled, brake_motor_ok, acu_mode, res_event, go_event,
			task_done, brake_released, beep_done, r2d_done} = '0;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// {ts, asms, ebs, bmok}, task, {res, go, done, released, beep_done, r2d_done}
		offer_tick({4'b0000, TASK_DEFAULT, 6'b000000});
		offer_tick({4'b1111, TASK_UNUSED, 6'b011111});
		offer_tick({4'b1000, TASK_MANUAL, 6'b000000});
		offer_tick({4'b1111, TASK_DEFAULT, 6'b001111});
		offer_tick({4'b0000, TASK_MANUAL, 6'b000000});
		offer_tick({4'b1111, TASK_AUTO, 6'b010000});
		offer_tick({4'b1111, TASK_AUTO, 6'b000000});
		offer_tick({4'b1111, TASK_AUTO, 6'b010001});
		offer_tick({4'b1111, TASK_AUTO, 6'b000001});
		offer_tick({4'b1111, TASK_AUTO, 6'b001000});
		offer_tick({4'b1111, TASK_AUTO, 6'b100110});
		offer_tick({4'b0000, TASK_DEFAULT, 6'b000110});
		offer_tick({4'b0000, TASK_DEFAULT, 6'b000100});
		offer_tick({4'b1111, TASK_AUTO, 6'b000000});
		offer_tick({4'b1101, TASK_AUTO, 6'b100000});
		offer_tick({4'b1111, TASK_AUTO, 6'b000010});
		offer_tick({4'b0000, TASK_AUTO, 6'b000100});
		offer_tick({4'b1111, TASK_AUTO, 6'b000000});
		offer_tick({4'b1111, TASK_AUTO, 6'b000000});
		offer_tick({4'b0000, TASK_DEFAULT, 6'b000110});
		offer_tick({4'b0000, TASK_DEFAULT, 6'b000100});
		offer_tick({4'b1111, TASK_AUTO, 6'b010000});
		offer_tick({4'b1111, TASK_AUTO, 6'b010000});
		offer_tick({4'b0111, TASK_AUTO, 6'b001000});
		offer_tick({4'b1011, TASK_MANUAL, 6'b000110});

		while (n_sent < N_DIRECTED + N_RANDOM) begin
			if (!paused && n_sent >= 900) begin
				paused = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
			0: begin
				k = $urandom_range(3, 8);
				repeat (k) offer_tick(12'($urandom));
			end
			1: begin
				repeat (3) offer_tick(recover_item());
				it = 12'($urandom);
				it.ts_closed = 1'b1;
				it.asms_closed = 1'b0;
				it.ebs_enabled = 1'b0;
				it.acu_mode = TASK_MANUAL;
				offer_tick(it);
				k = $urandom_range(2, 6);
				repeat (k) begin
					it = 12'($urandom);
					it.ts_closed = 1'b1;
					offer_tick(it);
				end
				it = 12'($urandom);
				it.ts_closed = 1'b0;
				offer_tick(it);
			end
			default: begin
				repeat (3) offer_tick(recover_item());
				offer_tick(cruise_item(1'($urandom), 1'b0, 5));
				k = $urandom_range(0, 3);
				repeat (k) offer_tick(cruise_item(1'b0, 1'b0, 5));
				offer_tick(cruise_item(1'b1, 1'b0, 5));
				k = $urandom_range(1, 6);
				repeat (k) offer_tick(cruise_item(1'b0, 1'b0, 5));
				offer_tick(cruise_item(1'b0, $urandom_range(0, 9) < 7, 5));
				k = $urandom_range(0, 3);
				repeat (k) offer_tick(cruise_item(1'b0, 1'b0, 30));
			end
			endcase
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/asmf_pkg.sv
rtl/asmf_core.sv
rtl/autonomous_system_mode_fsm.sv
tb/asmf_mode_checker.sv
tb/autonomous_system_mode_fsm_tb.sv
